/* rtl/radix_to_ascii_digits_unit_assert.svh */
// ----------------------------------------------------------------------------
// radix to ascii digits assertion macros
// concurrent assertion helpers used by radix_to_ascii_digits_unit
// ----------------------------------------------------------------------------
`ifndef RADIX_TO_ASCII_DIGITS_UNIT_ASSERT_SVH
`define RADIX_TO_ASCII_DIGITS_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is applied
`define R2A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is applied
`define R2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/r2a_pkg.sv */
// ----------------------------------------------------------------------------
// r2a_pkg
// shared widths, constants and helpers of the radix to ascii digits unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package r2a_pkg;

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  // one quotient bit per divider step
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR   = 7'd48;
  localparam logic [CHAR_W-1:0]  LETTER_BASE = 7'd65;

  typedef struct packed {
    logic busy;
    logic done;
  } r2a_div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = ZERO_CHAR + CHAR_W'(d);
    end else begin
      c = LETTER_BASE + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

/* rtl/r2a_div.sv */
// ----------------------------------------------------------------------------
// r2a_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module r2a_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [r2a_pkg::VALUE_W-1:0]   dividend_i,
  input  logic [r2a_pkg::RADIX_W-1:0]   divisor_i,
  output r2a_pkg::r2a_div_stat_t        stat_o,
  output logic [r2a_pkg::VALUE_W-1:0]   quotient_o,
  output logic [r2a_pkg::DIGIT_W-1:0]   remainder_o
);
  import r2a_pkg::*;

  logic [VALUE_W-1:0] quo_q;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] dvs_q;
  logic [STEP_W-1:0]  cnt_q;
  logic               busy_q, done_q;

  logic [DIGIT_W:0] trial, diff;
  logic             ge;

  // shift the next dividend bit into the partial remainder
  always_comb begin
    trial = {rem_q, quo_q[VALUE_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[VALUE_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/radix_to_ascii_digits_unit.sv */
// ----------------------------------------------------------------------------
// radix_to_ascii_digits_unit
// converts a 31-bit unsigned value into ascii digits of base 2..36
// ----------------------------------------------------------------------------
// channel   dir  tdata                               tlast
// s_axis    in   [30:0] value, [36:31] radix         -
// m_axis    out  [6:0] digit_char, [7] zero          last (final character)
//
// each digit comes from one pass of the bit-serial divider over all value bits;
// each character then passes through stack read, output load and transfer,
// and the transfer waits until the sink is ready
// one item is in flight at a time; s_axis_tready_o is high only while idle
// m_axis_tvalid_o holds until the sink takes the character
// rst_ni clears control state only; the digit stack is never cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_to_ascii_digits_unit #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side: [30:0] value, [36:31] radix, [39:37] zero
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [r2a_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // master side: [6:0] digit_char, [7] zero
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [r2a_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import r2a_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_READ = 5'b00100,
    S_LOAD = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [RADIX_W-1:0] radix_q;
  logic [DIGIT_W-1:0] rd_data_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  // digit stack, no reset
  logic [DIGIT_W-1:0] stack_mem [STACK_DEPTH];

  logic               in_xfer, out_xfer;
  logic [RADIX_W-1:0] radix_in, radix_clamped;
  logic               div_start;
  logic [VALUE_W-1:0] div_dividend;
  logic [RADIX_W-1:0] div_divisor;
  r2a_div_stat_t      div_stat;
  logic [VALUE_W-1:0] div_quo;
  logic [DIGIT_W-1:0] div_rem;
  logic               push, pop, stack_full;
  logic [CNT_W-1:0]   pop_cnt;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // bases below two act as two, above thirty-six as thirty-six
  assign radix_in = s_axis_tdata_i[VALUE_W +: RADIX_W];
  always_comb begin
    if (radix_in < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (radix_in > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = radix_in;
    end
  end

  // divider restarts on the quotient until it reaches zero
  assign push         = (state_q == S_DIV) && div_stat.done;
  assign div_start    = in_xfer || (push && (div_quo != '0));
  assign div_dividend = in_xfer ? s_axis_tdata_i[VALUE_W-1:0] : div_quo;
  assign div_divisor  = in_xfer ? radix_clamped : radix_q;

  r2a_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign stack_full = (count_q >= CNT_W'(STACK_DEPTH));
  assign pop        = (state_q == S_READ);
  assign pop_cnt    = count_q - 1'b1;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DIV;
          count_d = '0;
        end
      end
      S_DIV: begin
        if (push) begin
          if (!stack_full) begin
            count_d = count_q + 1'b1;
          end
          if (div_quo == '0) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        count_d = pop_cnt;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_xfer) begin
          state_d = last_q ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // stack write and registered read
  always_ff @(posedge clk_i) begin
    if (push && !stack_full) begin
      stack_mem[count_q[IDX_W-1:0]] <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_data_q <= stack_mem[pop_cnt[IDX_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      radix_q <= radix_clamped;
    end
    if (state_q == S_LOAD) begin
      char_q <= digit_to_ascii(rd_data_q);
      last_q <= (count_q == '0);
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_EMIT);
  assign m_axis_tdata_o  = {1'b0, char_q};
  assign m_axis_tlast_o  = last_q;

  `include "radix_to_ascii_digits_unit_assert.svh"

  `R2A_ASSERT_NOW(a_div_only_in_div, div_stat.busy, state_q == S_DIV, "divider busy outside division")
  `R2A_ASSERT_NOW(a_idle_stack_empty, s_axis_tready_o, count_q == '0, "stack not drained at idle")
  `R2A_ASSERT_NOW(a_last_empties_stack, m_axis_tvalid_o && m_axis_tlast_o, count_q == '0, "last character with digits left")
  `R2A_ASSERT_NEXT(a_final_push_reads, push && (div_quo == '0), state_q == S_READ, "no readout after final digit")

endmodule

/* bench/radix_to_ascii_digits_unit_tb.sv */
// ----------------------------------------------------------------------------
// radix_to_ascii_digits_unit_tb
// self-checking bench: numbers go in on s_axis, every ascii digit that leaves
// m_axis is compared against a digit queue filled from spelled-out rows or a behavioral divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_to_ascii_digits_unit_tb;
  import r2a_pkg::*;

  localparam int unsigned RESET_CYCLES     = 11;
  localparam int unsigned CYCLE_LIMIT      = 3_000_000;
  localparam int unsigned DRAIN_CYCLES     = 200;
  localparam int unsigned SINK_HOLD_CYCLES = 1500;
  localparam int unsigned RANDOM_PER_PHASE = 64;
  localparam int unsigned PRESSURE_ITEMS   = 4;
  localparam int unsigned NUM_PHASES       = 3;
  localparam int unsigned TEXT_CHARS       = 32;
  localparam int unsigned TEXT_W           = 8 * TEXT_CHARS;
  localparam int unsigned NUM_DIRECTED     = 24;

  // one character transfer on m_axis
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } digit_xfer_t;

  // directed row: digits spelled out as a string, or zero to use the divider
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic [TEXT_W-1:0]  text;
  } number_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // [30:0] value, [36:31] radix, [39:37] zero
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // [6:0] digit_char, [7] zero
  logic                   m_axis_tlast_o;

  digit_xfer_t  pending_digits [$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_idle_pct = 0;
  int unsigned  sink_hold_seq = 0;

  int unsigned  src_idle_by_phase [NUM_PHASES] = '{18, 76, 0};
  int unsigned  snk_idle_by_phase [NUM_PHASES] = '{76, 18, 0};

  number_row_t directed_numbers [NUM_DIRECTED] = '{
    '{31'd0,          6'd10, "0"},
    '{31'd0,          6'd2,  "0"},
    '{31'd0,          6'd36, "0"},
    '{31'd0,          6'd0,  "0"},
    '{31'd0,          6'd63, "0"},
    '{31'h7FFF_FFFF,  6'd10, "2147483647"},
    '{31'h7FFF_FFFF,  6'd16, "7FFFFFFF"},
    '{31'h7FFF_FFFF,  6'd36, "ZIK0ZJ"},
    '{31'h7FFF_FFFF,  6'd8,  "17777777777"},
    '{31'h7FFF_FFFF,  6'd63, "ZIK0ZJ"},
    '{31'h7FFF_FFFF,  6'd2,  '0},
    '{31'h7FFF_FFFF,  6'd0,  '0},
    '{31'd35,         6'd36, "Z"},
    '{31'd9,          6'd10, "9"},
    '{31'd10,         6'd11, "A"},
    '{31'd1,          6'd2,  "1"},
    '{31'd2,          6'd2,  "10"},
    '{31'd5,          6'd0,  "101"},
    '{31'd5,          6'd1,  "101"},
    '{31'd35,         6'd37, "Z"},
    '{31'd36,         6'd63, "10"},
    '{31'd1295,       6'd36, "ZZ"},
    '{31'h4000_0000,  6'd2,  '0},
    '{31'd12_345_678, 6'd7,  '0}
  };

  radix_to_ascii_digits_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // divide repeatedly, then queue the remainders most significant first
  function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
    logic [VALUE_W-1:0] quotient;
    logic [RADIX_W-1:0] base;
    logic [DIGIT_W-1:0] remainders [$];
    logic [DIGIT_W-1:0] d;
    digit_xfer_t        x;
    base = radix;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    quotient = value;
    do begin
      remainders.push_back(DIGIT_W'(quotient % base));
      quotient = quotient / base;
    end while (quotient != '0);
    while (remainders.size() > 0) begin
      d = remainders.pop_back();
      if (d < DIGIT_TEN) begin
        x.digit_char = ZERO_CHAR + CHAR_W'(d);
      end else begin
        x.digit_char = LETTER_BASE + CHAR_W'(d - DIGIT_TEN);
      end
      x.last = (remainders.size() == 0);
      pending_digits.push_back(x);
    end
  endfunction

  // offer one number; valid is only lowered inside an idle gap
  task automatic offer_number(input logic [VALUE_W-1:0] value,
                              input logic [RADIX_W-1:0] radix,
                              input logic [TEXT_W-1:0]  text);
    digit_xfer_t x;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_W'({radix, value});
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (text == '0) begin
      predict_digits(value, radix);
    end else begin
      // spelled-out digits, right-justified in the row
      for (int k = TEXT_CHARS - 1; k >= 0; k--) begin
        if (text[8*k +: 8] != 8'd0) begin
          x.digit_char = CHAR_W'(text[8*k +: 8]);
          x.last       = (k == 0);
          pending_digits.push_back(x);
        end
      end
    end
  endtask

  // random width spreads numbers over every length; out-of-range radixes now and then
  task automatic offer_random_number();
    int unsigned        nbits;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    nbits = $urandom_range(VALUE_W, 0);
    value = VALUE_W'($urandom) >> (VALUE_W - nbits);
    case ($urandom_range(9, 0))
      0:       radix = RADIX_W'($urandom_range(63, 0));
      1:       radix = RADIX_MIN;
      2:       radix = RADIX_MAX;
      default: radix = RADIX_W'($urandom_range(36, 2));
    endcase
    offer_number(value, radix, '0);
  endtask

  task automatic wait_for_digits();
    s_axis_tvalid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
  endtask

  // sink: random back-pressure, or a long hold when the sequence number moves
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_seq != hold_seen) begin
        hold_seen = sink_hold_seq;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // character checker
  always @(posedge clk_i) begin
    digit_xfer_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_digits.size() == 0) begin
        $error("character transfer with none pending: tdata=%h tlast=%b",
               m_axis_tdata_o, m_axis_tlast_o);
        error_count++;
      end else begin
        want = pending_digits.pop_front();
        if (m_axis_tdata_o[CHAR_W-1:0] !== want.digit_char) begin
          $error("digit_char: expected %0d, got %0d", want.digit_char,
                 m_axis_tdata_o[CHAR_W-1:0]);
          error_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_axis_tlast_o);
          error_count++;
        end
        if (m_axis_tdata_o[OUT_TDATA_W-1:CHAR_W] !== '0) begin
          $error("tdata padding: expected 0, got %b", m_axis_tdata_o[OUT_TDATA_W-1:CHAR_W]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct = src_idle_by_phase[ph];
      snk_idle_pct = snk_idle_by_phase[ph];
      if (ph == 0) begin
        for (int i = 0; i < NUM_DIRECTED; i++) begin
          offer_number(directed_numbers[i].value, directed_numbers[i].radix,
                       directed_numbers[i].text);
        end
      end
      repeat (RANDOM_PER_PHASE) offer_random_number();
      if (ph == 0) begin
        // sink stalls long enough for the unit to back up into s_axis
        sink_hold_seq <= sink_hold_seq + 1;
        repeat (PRESSURE_ITEMS) offer_random_number();
        wait_for_digits();
      end
    end

    wait_for_digits();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_digits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
